@@ hw/rtl/b2da_pkg.sv @@
// Shared types and constants for the binary to decimal ASCII converter.
// Used by the front, queue, back and top-level modules; depends on nothing.
package b2da_pkg;

	// Default sizing, handed down as top-level parameter defaults.
	localparam int MAX_DIGITS_DEF = 16;
	localparam int VALUE_BITS_DEF = 32;

	// Fixed field widths.
	localparam int MIN_W   = 5;   // min_digits field
	localparam int CHAR_W  = 6;   // digit_char field
	localparam int DIGIT_W = 4;   // one BCD digit
	localparam int WIDE_W  = 6;   // digit counts up to 63 for compares

	// Value bits consumed by the shift-add-3 unit in one cycle.
	localparam int BITS_PER_STEP = 4;

	// ASCII code of the digit zero.
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	// Front-end sequencer states.
	typedef enum logic [1:0] {
		FS_IDLE,
		FS_CONV,
		FS_DONE
	} front_state_t;

	// Queue status seen by its producer and consumer.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

@@ hw/rtl/binary_to_decimal_ascii.sv @@
// Top level of the binary to decimal ASCII converter: front end, queue and
// back end. Depends on b2da_pkg, b2da_front, b2da_queue and b2da_back.
//
//   Channel  Direction  Contents
//   s_axis   in         tdata: number, min_digits (lowest bit up), zero filled
//   m_axis   out        tdata: digit_char, zero filled; tlast: last
//
// The front end accepts a value, converts it in the shift-add-3 unit and
// queues the result; it takes no new value until the last one is queued.
// The back end fetches an entry and then sends one digit per cycle while
// m_axis is not stalled, fetching the next entry once the last is emitted.
// Reset clears all control state. A stall on m_axis backs up into the queue;
// the front end keeps converting until the two-entry queue is full.
module binary_to_decimal_ascii #(
	parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF,
	parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
	parameter int S_DATA_W   = ((VALUE_BITS + b2da_pkg::MIN_W + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,   // number, min_digits
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [7:0]          m_axis_tdata,   // digit_char
	output logic                m_axis_tlast
);
	import b2da_pkg::*;

	localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
	localparam int ENTRY_W = MAX_DIGITS * DIGIT_W + CNT_W;

	q_status_t          q_status;
	logic               push;
	logic               pop;
	logic [ENTRY_W-1:0] push_data;
	logic [ENTRY_W-1:0] pop_data;
	logic [CHAR_W-1:0]  out_char;

	b2da_front #(
		.MAX_DIGITS (MAX_DIGITS),
		.VALUE_BITS (VALUE_BITS),
		.CNT_W      (CNT_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_number     (s_axis_tdata[VALUE_BITS-1:0]),
		.in_min_digits (s_axis_tdata[VALUE_BITS +: MIN_W]),
		.q_status      (q_status),
		.push          (push),
		.push_data     (push_data)
	);

	b2da_queue #(
		.ENTRY_W (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	b2da_back #(
		.MAX_DIGITS (MAX_DIGITS),
		.CNT_W      (CNT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_last  (m_axis_tlast)
	);

	// Digit code in the low bits, upper bits zero.
	assign m_axis_tdata = {{(8 - CHAR_W){1'b0}}, out_char};

endmodule

@@ hw/rtl/b2da_queue.sv @@
// Two-entry queue of converted values between the front and back ends.
// Depends on b2da_pkg for the status struct.
module b2da_queue #(
	parameter int ENTRY_W = 68
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [ENTRY_W-1:0] push_data,
	input  logic               pop,
	output logic [ENTRY_W-1:0] pop_data,
	output b2da_pkg::q_status_t status
);
	import b2da_pkg::*;

	logic [ENTRY_W-1:0] entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         fill_q;

	// Status flags from the fill level.
	assign status.full  = (fill_q == 2'd2);
	assign status.empty = (fill_q == 2'd0);
	assign pop_data     = entry_q[rd_ptr_q];

	// Pointer and fill bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ hw/rtl/b2da_front.sv @@
// Front end: accepts a value, converts it to BCD with a shift-add-3 unit
// four bits per cycle, works out the digit count and queues the result.
// Depends on b2da_pkg.
module b2da_front #(
	parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF,
	parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
	parameter int CNT_W      = $clog2(MAX_DIGITS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [VALUE_BITS-1:0]             in_number,
	input  logic [b2da_pkg::MIN_W-1:0]        in_min_digits,
	input  b2da_pkg::q_status_t               q_status,
	output logic                              push,
	output logic [MAX_DIGITS*b2da_pkg::DIGIT_W+CNT_W-1:0] push_data
);
	import b2da_pkg::*;

	localparam int NSTEP  = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PAD_W  = NSTEP * BITS_PER_STEP;
	localparam int BCD_W  = MAX_DIGITS * DIGIT_W;
	localparam int STEP_W = $clog2(NSTEP + 1);

	front_state_t         state_q, state_d;
	logic [PAD_W-1:0]     val_q;
	logic [BCD_W-1:0]     bcd_q;
	logic                 ovf_q;
	logic [MIN_W-1:0]     min_q;
	logic [STEP_W-1:0]    step_q;

	logic [PAD_W-1:0]     val_n;
	logic [BCD_W-1:0]     bcd_n;
	logic                 ovf_n;
	logic [WIDE_W-1:0]    natural;
	logic [WIDE_W-1:0]    want;
	logic [WIDE_W-1:0]    count;

	// Four shift-add-3 steps; a carry out of the top digit marks overflow.
	always_comb begin
		val_n = val_q;
		bcd_n = bcd_q;
		ovf_n = ovf_q;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			for (int d = 0; d < MAX_DIGITS; d++) begin
				if (bcd_n[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
					bcd_n[d*DIGIT_W +: DIGIT_W] = bcd_n[d*DIGIT_W +: DIGIT_W] + 4'd3;
				end
			end
			ovf_n = ovf_n | bcd_n[BCD_W-1];
			bcd_n = {bcd_n[BCD_W-2:0], val_n[PAD_W-1]};
			val_n = {val_n[PAD_W-2:0], 1'b0};
		end
	end

	// Natural length from the highest nonzero digit, and the final count.
	always_comb begin
		natural = WIDE_W'(1);
		for (int d = 0; d < MAX_DIGITS; d++) begin
			if (bcd_q[d*DIGIT_W +: DIGIT_W] != 4'd0) begin
				natural = WIDE_W'(d + 1);
			end
		end
		if (ovf_q) begin
			natural = WIDE_W'(MAX_DIGITS);
		end
		if (WIDE_W'(min_q) > WIDE_W'(MAX_DIGITS)) begin
			want = WIDE_W'(MAX_DIGITS);
		end else begin
			want = WIDE_W'(min_q);
		end
		count = (want > natural) ? want : natural;
	end

	assign push_data = {count[CNT_W-1:0], bcd_q};

	// Sequencer next state and handshake outputs.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			FS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = FS_CONV;
				end
			end
			FS_CONV: begin
				if (step_q == STEP_W'(NSTEP - 1)) begin
					state_d = FS_DONE;
				end
			end
			FS_DONE: begin
				if (!q_status.full) begin
					push    = 1'b1;
					state_d = FS_IDLE;
				end
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Conversion registers: load on a transfer, step while converting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q  <= '0;
			bcd_q  <= '0;
			ovf_q  <= 1'b0;
			min_q  <= '0;
			step_q <= '0;
		end else if (state_q == FS_IDLE && in_valid) begin
			val_q  <= PAD_W'(in_number);
			bcd_q  <= '0;
			ovf_q  <= 1'b0;
			min_q  <= in_min_digits;
			step_q <= '0;
		end else if (state_q == FS_CONV) begin
			val_q  <= val_n;
			bcd_q  <= bcd_n;
			ovf_q  <= ovf_n;
			step_q <= step_q + STEP_W'(1);
		end
	end

endmodule

@@ hw/rtl/b2da_back.sv @@
// Back end: takes converted values from the queue and sends their digits
// as ASCII codes, most significant first, through an output register.
// Depends on b2da_pkg.
module b2da_back #(
	parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF,
	parameter int CNT_W      = $clog2(MAX_DIGITS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  b2da_pkg::q_status_t               q_status,
	input  logic [MAX_DIGITS*b2da_pkg::DIGIT_W+CNT_W-1:0] pop_data,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [b2da_pkg::CHAR_W-1:0]       out_char,
	output logic                              out_last
);
	import b2da_pkg::*;

	localparam int BCD_W = MAX_DIGITS * DIGIT_W;
	localparam int IDX_W = $clog2(MAX_DIGITS);

	logic                busy_q;
	logic [BCD_W-1:0]    digits_q;
	logic [IDX_W-1:0]    idx_q;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;

	logic                slot_free;
	logic                emit;
	logic [CNT_W-1:0]    pop_count;
	logic [DIGIT_W-1:0]  digit;

	assign slot_free = !out_valid_q || out_ready;
	assign emit      = busy_q && slot_free;
	assign pop       = !busy_q && !q_status.empty;
	assign pop_count = pop_data[BCD_W +: CNT_W];
	assign digit     = digits_q[idx_q*DIGIT_W +: DIGIT_W];

	assign out_valid = out_valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	// Digit walk over the current value, highest place first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			digits_q <= '0;
			idx_q    <= '0;
		end else if (pop) begin
			busy_q   <= 1'b1;
			digits_q <= pop_data[BCD_W-1:0];
			idx_q    <= IDX_W'(pop_count - CNT_W'(1));
		end else if (emit) begin
			if (idx_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - IDX_W'(1);
			end
		end
	end

	// Output register; a digit is loaded when the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
			char_q      <= ASCII_ZERO + CHAR_W'(digit);
			last_q      <= (idx_q == '0);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

@@ test/binary_to_decimal_ascii_tb.sv @@
// Testbench for binary_to_decimal_ascii: it drives values and minimum digit counts in,
// predicts each ASCII digit and checks every digit transfer as it leaves the block.
// Depends on b2da_pkg and the binary_to_decimal_ascii RTL.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;
	import b2da_pkg::*;

	localparam int MAX_DIGITS = MAX_DIGITS_DEF;
	localparam int VALUE_BITS = VALUE_BITS_DEF;
	localparam int IN_W       = ((VALUE_BITS + MIN_W + 7) / 8) * 8;
	localparam int DRAIN_MAX  = 20000;
	localparam int SETTLE     = 30;

	// How the output side takes transfers.
	typedef enum logic [1:0] {
		SINK_PATTERN,
		SINK_ALWAYS,
		SINK_SLOW
	} sink_mode_t;

	// One expected digit transfer.
	typedef struct {
		logic [CHAR_W-1:0] digit_char;
		logic              last;
	} digit_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;    // number, min_digits, zero fill
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;         // digit_char, zero fill
	logic              m_axis_tlast;

	digit_t      pending_digits[$];
	int          mismatch_count = 0;
	sink_mode_t  sink_mode = SINK_PATTERN;
	bit          source_bursty = 1'b1;
	int          burst_left = 0;
	int          seg_left = 0;
	int          seg_kind = 0;
	int          cycle_count = 0;

	binary_to_decimal_ascii dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always #6 clk = ~clk;

	// Work out the digits that one value produces and queue them, most significant first.
	function automatic void queue_decimal_digits(input logic [VALUE_BITS-1:0] number,
			input logic [MIN_W-1:0] min_digits);
		logic [DIGIT_W-1:0] digits[MAX_DIGITS];
		logic [VALUE_BITS-1:0] rest;
		int natural_len;
		int want;
		int count;
		digit_t d;
		for (int i = 0; i < MAX_DIGITS; i++) digits[i] = '0;
		rest = number;
		natural_len = 0;
		do begin
			if (natural_len < MAX_DIGITS) digits[natural_len] = DIGIT_W'(rest % 10);
			natural_len++;
			rest = rest / 10;
		end while (rest != 0);
		want = (min_digits > MAX_DIGITS) ? MAX_DIGITS : int'(min_digits);
		count = (natural_len > want) ? natural_len : want;
		if (count > MAX_DIGITS) count = MAX_DIGITS;
		for (int i = 0; i < count; i++) begin
			d.digit_char = ASCII_ZERO + CHAR_W'(digits[count - 1 - i]);
			d.last = (i == count - 1);
			pending_digits.push_back(d);
		end
	endfunction

	// Values spread evenly over decimal lengths, with some plain random words.
	function automatic logic [VALUE_BITS-1:0] random_number();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] span_pick;
		int n_digits;
		if ($urandom_range(0, 3) == 0) return $urandom;
		n_digits = $urandom_range(1, 10);
		lo = 64'd1;
		repeat (n_digits - 1) lo = lo * 10;
		hi = lo * 10 - 1;
		if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
		if (n_digits == 1) lo = 64'd0;
		span_pick = {$urandom, $urandom} % (hi - lo + 1);
		return VALUE_BITS'(lo + span_pick);
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// Send one value; in bursty mode a random gap opens before each new burst.
	task automatic send_value(input logic [VALUE_BITS-1:0] number,
			input logic [MIN_W-1:0] min_digits);
		int gap;
		if (source_bursty) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				if (gap > 0) begin
					s_axis_tvalid <= 1'b0;
					s_axis_tdata <= IN_W'({$urandom, $urandom});
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_W - VALUE_BITS - MIN_W){1'b0}}, min_digits, number};
		do @(posedge clk); while (!s_axis_tready);
		queue_decimal_digits(number, min_digits);
	endtask

	// Field extremes, padding, the clamp of the minimum and the decimal length steps 1-2, 2-3 and 9-10.
	task automatic test_corner_values();
		sink_mode = SINK_PATTERN;
		source_bursty = 1'b1;
		send_value(32'd0, 5'd0);
		send_value(32'd0, 5'd1);
		send_value(32'd0, 5'd16);
		send_value(32'd0, 5'd17);
		send_value(32'd0, 5'd31);
		send_value(32'hFFFF_FFFF, 5'd0);
		send_value(32'hFFFF_FFFF, 5'd10);
		send_value(32'hFFFF_FFFF, 5'd11);
		send_value(32'hFFFF_FFFF, 5'd31);
		send_value(32'd9, 5'd0);
		send_value(32'd10, 5'd0);
		send_value(32'd99, 5'd1);
		send_value(32'd100, 5'd2);
		send_value(32'd999_999_999, 5'd9);
		send_value(32'd1_000_000_000, 5'd15);
		send_value(32'd1, 5'd16);
		send_value(32'd12345, 5'd3);
		send_value(32'd12345, 5'd8);
		send_value(32'h8000_0000, 5'd12);
		send_value(32'h7FFF_FFFF, 5'd20);
		send_value(32'h5555_5555, 5'd5);
		send_value(32'hAAAA_AAAA, 5'd14);
	endtask

	// Random values and minimums with a bursty source and a patterned sink.
	task automatic test_random_values(input int n_items);
		logic [MIN_W-1:0] mind;
		sink_mode = SINK_PATTERN;
		source_bursty = 1'b1;
		for (int i = 0; i < n_items; i++) begin
			mind = ($urandom_range(0, 4) == 0) ? MIN_W'($urandom_range(0, 31))
				: MIN_W'($urandom_range(0, MAX_DIGITS));
			send_value(random_number(), mind);
		end
	endtask

	// Back to back input with the sink always ready.
	task automatic test_full_rate(input int n_items);
		sink_mode = SINK_ALWAYS;
		source_bursty = 1'b0;
		for (int i = 0; i < n_items; i++)
			send_value(random_number(), MIN_W'($urandom_range(0, 31)));
	endtask

	// Back to back input against a sink that rarely takes a transfer.
	task automatic test_backpressure(input int n_items);
		sink_mode = SINK_SLOW;
		source_bursty = 1'b0;
		for (int i = 0; i < n_items; i++)
			send_value(random_number(), MIN_W'($urandom_range(0, MAX_DIGITS)));
	endtask

	// Output side ready: a mode set by the test, or segments of random kind and length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (seg_left == 0) begin
			seg_kind <= $urandom_range(0, 3);
			seg_left <= $urandom_range(4, 40);
		end else begin
			seg_left <= seg_left - 1;
		end
		case (sink_mode)
			SINK_ALWAYS: m_axis_tready <= 1'b1;
			SINK_SLOW: m_axis_tready <= ($urandom_range(0, 5) == 0);
			default: begin
				case (seg_kind)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ((cycle_count % 5) < 3);
					2: m_axis_tready <= 1'($urandom_range(0, 1));
					default: m_axis_tready <= 1'b0;
				endcase
			end
		endcase
	end

	// Compare each digit transfer with the oldest expected digit.
	always @(posedge clk) begin
		digit_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_digits.size() == 0) begin
				report_mismatch($sformatf("unexpected digit 0x%02h last %0b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = pending_digits.pop_front();
				if (m_axis_tdata[CHAR_W-1:0] !== want.digit_char)
					report_mismatch($sformatf("digit_char 0x%02h, expected 0x%02h",
						m_axis_tdata[CHAR_W-1:0], want.digit_char));
				if (m_axis_tdata[7:CHAR_W] !== '0)
					report_mismatch($sformatf("tdata fill bits %b not zero",
						m_axis_tdata[7:CHAR_W]));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("last %b, expected %b",
						m_axis_tlast, want.last));
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_values();
		test_random_values(130);
		test_full_rate(30);
		test_backpressure(30);
		s_axis_tvalid <= 1'b0;
		sink_mode = SINK_ALWAYS;
		for (int w = 0; w < DRAIN_MAX && pending_digits.size() != 0; w++) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (pending_digits.size() != 0)
			report_mismatch($sformatf("%0d expected digits never arrived",
				pending_digits.size()));
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Hard limit on the run.
	initial begin
		#6000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ binary_to_decimal_ascii.f @@
hw/rtl/b2da_pkg.sv
hw/rtl/b2da_queue.sv
hw/rtl/b2da_front.sv
hw/rtl/b2da_back.sv
hw/rtl/binary_to_decimal_ascii.sv
test/binary_to_decimal_ascii_tb.sv
